>>> src/animation_phase_accumulator_defines.svh
// Assertion macros shared by the animation phase accumulator RTL.
// Used by the top level only; expects aclk and aresetn in scope.
`ifndef ANIMATION_PHASE_ACCUMULATOR_DEFINES_SVH
`define ANIMATION_PHASE_ACCUMULATOR_DEFINES_SVH

// Concurrent check, disabled while reset is held
`define APA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Concurrent check that also runs during reset
`define APA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> src/apa_pkg.sv
// Shared types and constants for the animation phase accumulator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package apa_pkg;

    // Field widths
    localparam int PHASE_W   = 24;
    localparam int FT_W      = 20;
    localparam int SPEED_W   = 20;
    localparam int LEN_W     = 25;
    localparam int STEP_W    = 25;
    localparam int FRAC_BITS = 16;
    localparam int FRAME_W   = 8;
    localparam int LERP_W    = 16;
    localparam int OML_W     = 17;
    localparam int FLAG_W    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = FT_W + SPEED_W;

    // Largest sequence in whole frames
    localparam longint MAX_FRAME_COUNT = 256;

    // 1.0 in 9.16 and the length bounds
    localparam logic [LEN_W-1:0] ONE_FIX = LEN_W'(1) << FRAC_BITS;
    localparam longint LEN_CAP    = longint'(1) << PHASE_W;
    localparam longint LEN_HI_RAW = MAX_FRAME_COUNT << FRAC_BITS;
    localparam longint LEN_HI     = (LEN_HI_RAW > LEN_CAP) ? LEN_CAP :
                                    ((LEN_HI_RAW < longint'(ONE_FIX)) ?
                                     longint'(ONE_FIX) : LEN_HI_RAW);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_HI[LEN_W-1:0];

    // Status flag bit positions
    localparam int FLAG_FINISHED = 0;
    localparam int FLAG_LOOPED   = 1;
    localparam int FLAG_START    = 2;
    localparam int FLAG_END      = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLAY_ENABLE = 3'd0,
        CFG_REVERSE_DIR = 3'd1,
        CFG_NO_LOOP     = 3'd2,
        CFG_SPEED       = 3'd3,
        CFG_LENGTH      = 3'd4
    } cfg_index_t;

    // Live configuration; len is already clamped to the legal range
    typedef struct packed {
        logic               play;
        logic               reverse;
        logic               no_loop;
        logic [SPEED_W-1:0] speed;
        logic [LEN_W-1:0]   len;
        logic [LEN_W-1:0]   len_m1;
    } cfg_t;

    // Pipeline stage control: take a new item, hand the held one on
    typedef struct packed {
        logic take;
        logic drain;
    } stage_ctl_t;

    // Updated phase and sticky flags
    typedef struct packed {
        logic [PHASE_W-1:0] position;
        logic [FLAG_W-1:0]  flags;
    } phase_res_t;

endpackage

>>> src/apa_step.sv
// Step stage: scales the frame time by the speed and saturates at the length.
// Depends on apa_pkg.
`timescale 1ns / 1ps

module apa_step
    import apa_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  stage_ctl_t         ctl,
    input  logic [FT_W-1:0]    frame_time,
    output logic               step_valid,
    output logic [STEP_W-1:0]  step
);

    logic                step_valid_reg;
    logic                step_valid_next;
    logic [STEP_W-1:0]   step_reg;
    logic [PROD_W-1:0]   prod;
    logic [STEP_W-1:0]   scaled;
    logic [STEP_W-1:0]   step_next;

    // 4.16 times 4.16, back to 8.16 (unity speed gives the frame time)
    assign prod   = PROD_W'(frame_time) * PROD_W'(cfg.speed);
    assign scaled = STEP_W'(prod[PROD_W-1:FRAC_BITS]);

    // Saturate so that a single wrap always suffices
    assign step_next = (scaled > cfg.len) ? cfg.len : scaled;

    // Occupancy of this stage
    always_comb begin
        if (ctl.take) begin
            step_valid_next = 1'b1;
        end else if (ctl.drain) begin
            step_valid_next = 1'b0;
        end else begin
            step_valid_next = step_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_valid_reg <= 1'b0;
        end else begin
            step_valid_reg <= step_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.take) begin
            step_reg <= step_next;
        end
    end

    assign step_valid = step_valid_reg;
    assign step       = step_reg;

endmodule

>>> src/apa_phase.sv
// Phase state: advances or retreats the 8.16 phase, wraps or clamps at the
// ends and keeps the sticky status flags. Depends on apa_pkg.
`timescale 1ns / 1ps

module apa_phase
    import apa_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               update,
    input  logic [STEP_W-1:0]  step,
    output phase_res_t         res_next
);

    logic [PHASE_W-1:0]  phase_reg;
    logic [PHASE_W-1:0]  phase_next;
    logic [FLAG_W-1:0]   flags_reg;
    logic [FLAG_W-1:0]   flags_next;

    logic [PHASE_W-1:0]  ph;
    logic [LEN_W:0]      fwd_sum;
    logic                fwd_end;
    logic [PHASE_W-1:0]  fwd_wrap;
    logic                rev_end;
    logic [PHASE_W-1:0]  rev_diff;
    logic [LEN_W-1:0]    rev_wrap_full;
    logic [PHASE_W-1:0]  rev_wrap;

    // Pull a phase left beyond a shortened length back inside
    assign ph = ({1'b0, phase_reg} >= cfg.len) ? cfg.len_m1[PHASE_W-1:0] : phase_reg;

    // Forward direction
    assign fwd_sum  = (LEN_W+1)'(ph) + (LEN_W+1)'(step);
    assign fwd_end  = (fwd_sum >= (LEN_W+1)'(cfg.len));
    assign fwd_wrap = PHASE_W'(fwd_sum - (LEN_W+1)'(cfg.len));

    // Reverse direction; landing exactly on zero is not an end
    assign rev_end       = (step > LEN_W'(ph));
    assign rev_diff      = ph - step[PHASE_W-1:0];
    assign rev_wrap_full = cfg.len - step + LEN_W'(ph);
    assign rev_wrap      = rev_wrap_full[PHASE_W-1:0];

    // Next phase and flags
    always_comb begin
        phase_next = phase_reg;
        flags_next = flags_reg;
        if (cfg.play) begin
            if (cfg.reverse) begin
                if (!rev_end) begin
                    phase_next = rev_diff;
                end else if (cfg.no_loop) begin
                    phase_next = '0;
                    flags_next[FLAG_FINISHED] = 1'b1;
                    flags_next[FLAG_START]    = 1'b1;
                end else begin
                    phase_next = rev_wrap;
                    flags_next[FLAG_LOOPED] = 1'b1;
                    flags_next[FLAG_END]    = 1'b1;
                end
            end else begin
                if (!fwd_end) begin
                    phase_next = fwd_sum[PHASE_W-1:0];
                end else if (cfg.no_loop) begin
                    phase_next = cfg.len_m1[PHASE_W-1:0];
                    flags_next[FLAG_FINISHED] = 1'b1;
                    flags_next[FLAG_END]      = 1'b1;
                end else begin
                    phase_next = fwd_wrap;
                    flags_next[FLAG_LOOPED] = 1'b1;
                    flags_next[FLAG_START]  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            flags_reg <= '0;
        end else if (update) begin
            phase_reg <= phase_next;
            flags_reg <= flags_next;
        end
    end

    assign res_next.position = phase_next;
    assign res_next.flags    = flags_next;

endmodule

>>> src/animation_phase_accumulator.sv
// Animation phase accumulator: 8.16 phase with speed scaling, wrap or clamp.
// Usage:
//   s_ channel carries one frame time per tick (4.16, s_tdata[19:0]).
//   m_ channel returns one result per tick: position, frame index, lerp and
//   one minus lerp in m_tdata, sticky finished/looped/start/end in m_tuser.
//   cfg channel writes play_enable, reverse_dir, no_loop, speed and length
//   by index; write it only while no tick is in flight. cfg_ready is always
//   high, and the length is clamped to the legal range as it is written.
// Timing:
//   Three register stages: input, scaled step, result. A tick accepted in
//   the input register moves to the scaled step register, then to the
//   result register, where it shows on m_. One tick per cycle sustained
//   while m_tready is high; the phase feedback loop (add, end compare,
//   wrap) sits in the last stage alone, the 20x20 speed multiply before it.
// Reset:
//   aresetn (synchronous, active low) empties the pipeline, zeroes the phase
//   and flags and restores the register defaults (speed and length 1.0).
// Stalls:
//   While m_tready is low the result holds; earlier stages keep filling and
//   s_tready drops only once every stage is occupied.
`timescale 1ns / 1ps
`include "animation_phase_accumulator_defines.svh"

module animation_phase_accumulator
    import apa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // Frame time requests
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,    // [19:0] frame_time, [23:20] zero

    // Results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [71:0]           m_tdata,    // [23:0] position, [31:24] frame_index,
                                              // [47:32] lerp, [64:48] one_minus_lerp,
                                              // [71:65] zero
    output logic [FLAG_W-1:0]     m_tuser,    // [0] finished, [1] looped,
                                              // [2] at_start, [3] at_end

    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [LEN_W-1:0]      cfg_data
);

    // Configuration registers
    logic               play_reg;
    logic               reverse_reg;
    logic               no_loop_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   len_m1_reg;
    logic [LEN_W-1:0]   len_next;
    cfg_t               cfg;

    // Pipeline control
    logic               in_valid_reg;
    logic               in_valid_next;
    logic [FT_W-1:0]    ft_reg;
    logic               s_accept;
    logic               step_valid;
    logic [STEP_W-1:0]  step;
    logic               out_load;
    logic               step_take;
    stage_ctl_t         step_ctl;

    // Result register
    logic               m_tvalid_reg;
    logic               m_tvalid_next;
    phase_res_t         res_next;
    logic [PHASE_W-1:0] pos_reg;
    logic [FLAG_W-1:0]  flags_out_reg;
    logic [LERP_W-1:0]  lerp;
    logic [OML_W-1:0]   one_minus_lerp;

    // Length clamp on write
    always_comb begin
        if (cfg_data < ONE_FIX) begin
            len_next = ONE_FIX;
        end else if (cfg_data > LEN_MAX) begin
            len_next = LEN_MAX;
        end else begin
            len_next = cfg_data;
        end
    end

    // Configuration write decode
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            play_reg    <= 1'b0;
            reverse_reg <= 1'b0;
            no_loop_reg <= 1'b0;
            speed_reg   <= ONE_FIX[SPEED_W-1:0];
            len_reg     <= ONE_FIX;
            len_m1_reg  <= ONE_FIX - LEN_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_PLAY_ENABLE: play_reg    <= cfg_data[0];
                CFG_REVERSE_DIR: reverse_reg <= cfg_data[0];
                CFG_NO_LOOP:     no_loop_reg <= cfg_data[0];
                CFG_SPEED:       speed_reg   <= cfg_data[SPEED_W-1:0];
                CFG_LENGTH: begin
                    len_reg    <= len_next;
                    len_m1_reg <= len_next - LEN_W'(1);
                end
                default: ;
            endcase
        end
    end

    assign cfg.play    = play_reg;
    assign cfg.reverse = reverse_reg;
    assign cfg.no_loop = no_loop_reg;
    assign cfg.speed   = speed_reg;
    assign cfg.len     = len_reg;
    assign cfg.len_m1  = len_m1_reg;

    // Stage handshakes: each stage loads when empty or when it moves on
    assign out_load  = step_valid && (!m_tvalid_reg || m_tready);
    assign step_take = in_valid_reg && (!step_valid || out_load);
    assign s_tready  = !in_valid_reg || step_take;
    assign s_accept  = s_tvalid && s_tready;

    assign step_ctl.take  = step_take;
    assign step_ctl.drain = out_load;

    // Input stage
    always_comb begin
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (step_take) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ft_reg <= s_tdata[FT_W-1:0];
        end
    end

    // Scaled step stage
    apa_step u_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .ctl        (step_ctl),
        .frame_time (ft_reg),
        .step_valid (step_valid),
        .step       (step)
    );

    // Phase update, committed as the result register loads
    apa_phase u_phase (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .update   (out_load),
        .step     (step),
        .res_next (res_next)
    );

    // Result register
    always_comb begin
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            pos_reg       <= res_next.position;
            flags_out_reg <= res_next.flags;
        end
    end

    // Result fields derived from the registered position
    assign lerp           = pos_reg[LERP_W-1:0];
    assign one_minus_lerp = ONE_FIX[OML_W-1:0] - OML_W'(lerp);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, one_minus_lerp, lerp,
                       pos_reg[PHASE_W-1:FRAC_BITS], pos_reg};
    assign m_tuser  = flags_out_reg;

    // A playing tick always leaves the position inside the sequence
    `APA_ASSERT(a_pos_in_range,
        (out_load && play_reg) |=> (LEN_W'(pos_reg) < len_reg),
        "position beyond sequence length")

    // Status flags never clear once a result has been loaded
    `APA_ASSERT(a_flags_sticky,
        m_tvalid_reg |=> ((flags_out_reg & $past(flags_out_reg)) == $past(flags_out_reg)),
        "sticky status flag cleared")

    // Finished can only be raised in no-loop mode
    `APA_ASSERT(a_finish_no_loop,
        (out_load && !no_loop_reg && m_tvalid_reg) |=>
            (flags_out_reg[FLAG_FINISHED] == $past(flags_out_reg[FLAG_FINISHED])),
        "finished set in loop mode")

    // The pipeline is empty right after reset
    `APA_ASSERT_ALWAYS(a_reset_empty,
        !aresetn |=> (!in_valid_reg && !step_valid && !m_tvalid_reg),
        "pipeline not empty after reset")

endmodule
